FILE: src/pbkm_pkg.sv
package pbkm_pkg;

  localparam int unsigned KnobBits  = 12;
  localparam int unsigned MenuSteps = 5;
  localparam int unsigned RegIdxW   = 1;

  localparam logic [2:0] MENU_SHOOT = 3'd0;
  localparam logic [2:0] MENU_WAIT  = 3'd1;
  localparam logic [2:0] MENU_VSTEP = 3'd2;
  localparam logic [2:0] MENU_HSTEP = 3'd3;
  localparam logic [2:0] MENU_READY = 3'd4;
  localparam logic [2:0] MENU_RUN   = 3'd5;
  localparam logic [5:0] BLINK_PERIOD = 6'd50;

  // configuration register indexes, decoded from paddr[2]
  localparam logic [RegIdxW-1:0] REG_DEBOUNCE = 1'b0;
  localparam logic [RegIdxW-1:0] REG_LONG     = 1'b1;

  localparam logic [7:0] DEBOUNCE_RESET = 8'd5;
  localparam logic [7:0] LONG_RESET     = 8'd100;

  typedef struct packed {
    logic [7:0] debounce_ticks;
    logic [7:0] long_ticks;
  } pbkm_cfg_t;

  typedef struct packed {
    logic short_press;
    logic long_press;
  } pbkm_btn_ev_t;

  typedef struct packed {
    logic [4:0]  led_pattern;
    logic [13:0] shoot_time_out;
    logic [13:0] wait_time_out;
    logic [3:0]  vertical_step_out;
    logic [5:0]  horizontal_step_out;
    logic        start_pulse;
    logic        park_pulse;
    logic        zero_pulse;
    logic [2:0]  knob_level;
    logic [2:0]  menu_position;
  } pbkm_res_t;

  function automatic logic [2:0] knob_quantize(input logic [KnobBits-1:0] avg);
    logic [2:0] lvl;
    if (avg <= 12'd100) begin
      lvl = 3'd4;
    end else if (avg <= 12'd1200) begin
      lvl = 3'd3;
    end else if (avg <= 12'd2600) begin
      lvl = 3'd2;
    end else if (avg <= 12'd3900) begin
      lvl = 3'd1;
    end else begin
      lvl = 3'd0;
    end
    return lvl;
  endfunction

  function automatic logic [13:0] shoot_lookup(input logic [2:0] lvl);
    logic [13:0] v;
    case (lvl)
      3'd0:    v = 14'd10000;
      3'd1:    v = 14'd5000;
      3'd2:    v = 14'd2200;
      3'd3:    v = 14'd1000;
      default: v = 14'd500;
    endcase
    return v;
  endfunction

  function automatic logic [13:0] wait_lookup(input logic [2:0] lvl);
    logic [13:0] v;
    case (lvl)
      3'd0:    v = 14'd10000;
      3'd1:    v = 14'd5000;
      3'd2:    v = 14'd4000;
      3'd3:    v = 14'd1000;
      default: v = 14'd100;
    endcase
    return v;
  endfunction

  function automatic logic [3:0] vert_lookup(input logic [2:0] lvl);
    logic [3:0] v;
    case (lvl)
      3'd0:    v = 4'd1;
      3'd1:    v = 4'd3;
      3'd2:    v = 4'd5;
      3'd3:    v = 4'd7;
      default: v = 4'd9;
    endcase
    return v;
  endfunction

  function automatic logic [5:0] horiz_lookup(input logic [2:0] lvl);
    logic [5:0] v;
    case (lvl)
      3'd0:    v = 6'd15;
      3'd1:    v = 6'd20;
      3'd2:    v = 6'd12;
      3'd3:    v = 6'd35;
      default: v = 6'd36;
    endcase
    return v;
  endfunction

endpackage

FILE: src/pbkm_if.sv
interface pbkm_in_if;
  logic                              valid;
  logic                              ready;
  logic                              button_one_pressed;
  logic                              button_two_pressed;
  logic [pbkm_pkg::KnobBits-1:0]     knob_sample;

  modport source (output valid, output button_one_pressed, output button_two_pressed,
                  output knob_sample, input ready);
  modport sink (input valid, input button_one_pressed, input button_two_pressed,
                input knob_sample, output ready);
endinterface

interface pbkm_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  led_pattern;
  logic [13:0] shoot_time_out;
  logic [13:0] wait_time_out;
  logic [3:0]  vertical_step_out;
  logic [5:0]  horizontal_step_out;
  logic        start_pulse;
  logic        park_pulse;
  logic        zero_pulse;
  logic [2:0]  knob_level;
  logic [2:0]  menu_position;

  modport source (output valid, output led_pattern, output shoot_time_out,
                  output wait_time_out, output vertical_step_out,
                  output horizontal_step_out, output start_pulse, output park_pulse,
                  output zero_pulse, output knob_level, output menu_position,
                  input ready);
  modport sink (input valid, input led_pattern, input shoot_time_out,
                input wait_time_out, input vertical_step_out,
                input horizontal_step_out, input start_pulse, input park_pulse,
                input zero_pulse, input knob_level, input menu_position,
                output ready);
endinterface

FILE: src/pbkm_cfg.sv
module pbkm_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output pbkm_pkg::pbkm_cfg_t cfg_o
);

  logic [7:0] debounce_q, debounce_d;
  logic [7:0] long_q, long_d;
  logic [pbkm_pkg::RegIdxW-1:0] idx;
  logic wr_en;

  assign idx    = paddr[2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    debounce_d = debounce_q;
    long_d     = long_q;
    if (wr_en) begin
      unique case (idx)
        pbkm_pkg::REG_DEBOUNCE: debounce_d = pwdata[7:0];
        pbkm_pkg::REG_LONG:     long_d     = pwdata[7:0];
        default:                ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      pbkm_pkg::REG_DEBOUNCE: prdata = {24'd0, debounce_q};
      pbkm_pkg::REG_LONG:     prdata = {24'd0, long_q};
      default:                prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= pbkm_pkg::DEBOUNCE_RESET;
      long_q     <= pbkm_pkg::LONG_RESET;
    end else begin
      debounce_q <= debounce_d;
      long_q     <= long_d;
    end
  end

  assign cfg_o.debounce_ticks = debounce_q;
  assign cfg_o.long_ticks     = long_q;

endmodule

FILE: src/pbkm_button.sv
module pbkm_button (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   held_i,
  input  pbkm_pkg::pbkm_cfg_t    cfg_i,
  output pbkm_pkg::pbkm_btn_ev_t ev_o
);

  logic [7:0] cnt_q, cnt_d;
  logic [8:0] cnt_inc;
  logic       below_cap;

  assign cnt_inc = {1'b0, cnt_q} + 9'd1;
  // ceiling is long limit plus one, or 255 when the limit is already 255
  assign below_cap = (cnt_q <= cfg_i.long_ticks) && (cnt_q != 8'hff);

  always_comb begin
    cnt_d          = cnt_q;
    ev_o.short_press = 1'b0;
    ev_o.long_press  = 1'b0;
    if (held_i) begin
      if (below_cap) begin
        cnt_d = cnt_inc[7:0];
        ev_o.long_press = (cnt_inc == {1'b0, cfg_i.long_ticks});
      end
    end else if ((cnt_q > cfg_i.debounce_ticks) && (cnt_q < cfg_i.long_ticks)) begin
      ev_o.short_press = 1'b1;
      cnt_d = 8'd0;
    end else if (cnt_q >= cfg_i.long_ticks) begin
      cnt_d = 8'd0;
    end else if (cnt_q != 8'd0) begin
      cnt_d = cnt_q - 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 8'd0;
    end else if (en_i) begin
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: src/panel_button_knob_menu_unit.sv
// Front panel controller: each request is one 100 Hz tick with two button levels and a knob
// sample, and yields one result with the LED pattern, the four timing settings, the start,
// park and zero pulses, the knob level and the menu step. A request is registered on entry
// and evaluated against the panel state once the result register is free or draining, and
// the result is registered in turn; the unit takes one request per cycle, limited only
// by the result register being drained. Debounce and long-press limits are written over the
// APB port at byte addresses 0 and 4 and should be changed only while no tick is in flight.
module panel_button_knob_menu_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  pbkm_in_if.sink     item_i,
  pbkm_out_if.source  result_o
);

  pbkm_pkg::pbkm_cfg_t    cfg;
  pbkm_pkg::pbkm_btn_ev_t ev_one, ev_two;
  pbkm_pkg::pbkm_res_t    res_d, res_q;

  logic                          s1_valid_q;
  logic                          s1_b1_q, s1_b2_q;
  logic [pbkm_pkg::KnobBits-1:0] s1_knob_q;
  logic                          out_valid_q;
  logic                          process, in_ready;

  logic [pbkm_pkg::KnobBits-1:0] knob_avg_q, knob_avg_d;
  logic [pbkm_pkg::KnobBits:0]   knob_sum;
  logic [2:0]  menu_q, menu_d, menu_inc;
  logic [13:0] shoot_q, shoot_d, wait_q, wait_d;
  logic [3:0]  vert_q, vert_d;
  logic [5:0]  horiz_q, horiz_d;
  logic [5:0]  blink_q, blink_d, blink_inc;
  logic [4:0]  led_q, led_d;
  logic [2:0]  lvl;
  logic        start;

  pbkm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pbkm_button u_btn_one (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (process),
    .held_i (s1_b1_q),
    .cfg_i  (cfg),
    .ev_o   (ev_one)
  );

  pbkm_button u_btn_two (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (process),
    .held_i (s1_b2_q),
    .cfg_i  (cfg),
    .ev_o   (ev_two)
  );

  // stage two fires when the result register is free or being drained
  assign process  = s1_valid_q && (!out_valid_q || result_o.ready);
  assign in_ready = !s1_valid_q || process;
  assign item_i.ready = in_ready;

  assign knob_sum   = {1'b0, knob_avg_q} + {1'b0, s1_knob_q};
  assign knob_avg_d = knob_sum[pbkm_pkg::KnobBits:1];
  assign lvl        = pbkm_pkg::knob_quantize(knob_avg_d);
  assign menu_inc   = menu_q + 3'd1;
  assign blink_inc  = blink_q + 6'd1;

  always_comb begin
    menu_d  = menu_q;
    led_d   = led_q;
    shoot_d = shoot_q;
    wait_d  = wait_q;
    vert_d  = vert_q;
    horiz_d = horiz_q;
    blink_d = blink_q;
    start   = 1'b0;

    // button one short press steps the menu, wrapping out of the run step too
    if (ev_one.short_press) begin
      menu_d = (menu_inc >= 3'(pbkm_pkg::MenuSteps)) ? pbkm_pkg::MENU_SHOOT : menu_inc;
    end
    if (ev_two.short_press && (menu_d == pbkm_pkg::MENU_READY)) begin
      menu_d = pbkm_pkg::MENU_RUN;
      led_d  = 5'd0;
      start  = 1'b1;
    end

    case (menu_d)
      pbkm_pkg::MENU_SHOOT: begin
        shoot_d = pbkm_pkg::shoot_lookup(lvl);
        led_d   = 5'h01;
      end
      pbkm_pkg::MENU_WAIT: begin
        wait_d = pbkm_pkg::wait_lookup(lvl);
        led_d  = 5'h02;
      end
      pbkm_pkg::MENU_VSTEP: begin
        vert_d = pbkm_pkg::vert_lookup(lvl);
        led_d  = 5'h04;
      end
      pbkm_pkg::MENU_HSTEP: begin
        horiz_d = pbkm_pkg::horiz_lookup(lvl);
        led_d   = 5'h08;
      end
      pbkm_pkg::MENU_READY: led_d = 5'h10;
      pbkm_pkg::MENU_RUN: begin
        blink_d = blink_inc;
        if (blink_inc >= pbkm_pkg::BLINK_PERIOD) begin
          blink_d = 6'd0;
          led_d   = led_d ^ 5'h04;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res_d.led_pattern         = led_d;
    res_d.shoot_time_out      = shoot_d;
    res_d.wait_time_out       = wait_d;
    res_d.vertical_step_out   = vert_d;
    res_d.horizontal_step_out = horiz_d;
    res_d.start_pulse         = start;
    res_d.park_pulse          = ev_two.long_press;
    res_d.zero_pulse          = ev_one.long_press;
    res_d.knob_level          = lvl;
    res_d.menu_position       = menu_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      knob_avg_q  <= '0;
      menu_q      <= pbkm_pkg::MENU_SHOOT;
      shoot_q     <= 14'd1000;
      wait_q      <= 14'd1000;
      vert_q      <= 4'd5;
      horiz_q     <= 6'd30;
      blink_q     <= 6'd0;
      led_q       <= 5'd0;
    end else begin
      if (in_ready) begin
        s1_valid_q <= item_i.valid;
      end
      if (process) begin
        out_valid_q <= 1'b1;
        knob_avg_q  <= knob_avg_d;
        menu_q      <= menu_d;
        shoot_q     <= shoot_d;
        wait_q      <= wait_d;
        vert_q      <= vert_d;
        horiz_q     <= horiz_d;
        blink_q     <= blink_d;
        led_q       <= led_d;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && item_i.valid) begin
      s1_b1_q   <= item_i.button_one_pressed;
      s1_b2_q   <= item_i.button_two_pressed;
      s1_knob_q <= item_i.knob_sample;
    end
    if (process) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid               = out_valid_q;
  assign result_o.led_pattern         = res_q.led_pattern;
  assign result_o.shoot_time_out      = res_q.shoot_time_out;
  assign result_o.wait_time_out       = res_q.wait_time_out;
  assign result_o.vertical_step_out   = res_q.vertical_step_out;
  assign result_o.horizontal_step_out = res_q.horizontal_step_out;
  assign result_o.start_pulse         = res_q.start_pulse;
  assign result_o.park_pulse          = res_q.park_pulse;
  assign result_o.zero_pulse          = res_q.zero_pulse;
  assign result_o.knob_level          = res_q.knob_level;
  assign result_o.menu_position       = res_q.menu_position;

endmodule
